// File: rtl/core/assert_macros.svh
// assertion macros shared by the calibration search rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/ocs_pkg.sv
// types and constants of the oscillator calibration search
package ocs_pkg;

	localparam logic [15:0] TARGET_RESET = 16'd1499;
	localparam logic [15:0] DEV_START    = 16'd9999;
	localparam logic [6:0]  FIRST_STEP   = 7'd64;
	localparam logic [7:0]  UPPER_BASE   = 8'd128;

	// action codes
	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_MEASURE = 1'b1;

	// status codes
	localparam logic [1:0] ST_TRIAL   = 2'd0;
	localparam logic [1:0] ST_DONE    = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	typedef struct packed {
		logic        action;
		logic [15:0] frame_length;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  trim_value;
		logic [15:0] deviation;
	} result_t;

endpackage

// File: rtl/core/ocs_item_if.sv
// input channel: start or measured frame length
interface ocs_item_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [15:0] frame_length;

	modport source (output valid, output action, output frame_length, input ready);
	modport sink (input valid, input action, input frame_length, output ready);
endinterface

// File: rtl/core/ocs_result_if.sv
// output channel: trial trim, done or ignored
interface ocs_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  trim_value;
	logic [15:0] deviation;

	modport source (output valid, output status, output trim_value, output deviation,
		input ready);
	modport sink (input valid, input status, input trim_value, input deviation,
		output ready);
endinterface

// File: rtl/core/ocs_search.sv
// search state and per-transaction update of the trim search
`include "assert_macros.svh"

module ocs_search import ocs_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   frame_target,
	input  logic          advance,
	input  item_t         item,
	output result_t       res
);

	logic        searching_q, searching_d;
	logic        upper_q, upper_d;
	logic [6:0]  step_q, step_d;
	logic [7:0]  trial_q, trial_d;
	logic [7:0]  best_trim_q, best_trim_d;
	logic [15:0] best_dev_q, best_dev_d;

	logic        len_below;
	logic [15:0] dev;
	logic        better;
	logic [7:0]  nb_trim;
	logic [15:0] nb_dev;
	logic [6:0]  half_step;
	logic [7:0]  first_lower;
	logic [7:0]  first_upper;

	assign len_below = item.frame_length < frame_target;
	assign dev       = len_below ? (frame_target - item.frame_length)
	                             : (item.frame_length - frame_target);
	assign better    = dev < best_dev_q;
	assign nb_trim   = better ? trial_q : best_trim_q;
	assign nb_dev    = better ? dev : best_dev_q;
	assign half_step = step_q >> 1;

	// first trial of a region follows a notional length of zero
	assign first_lower = (frame_target != 16'd0) ? {1'b0, FIRST_STEP}
	                                              : (8'd0 - {1'b0, FIRST_STEP});
	assign first_upper = (frame_target != 16'd0) ? (UPPER_BASE + {1'b0, FIRST_STEP})
	                                              : (UPPER_BASE - {1'b0, FIRST_STEP});

	always_comb begin
		searching_d = searching_q;
		upper_d     = upper_q;
		step_d      = step_q;
		trial_d     = trial_q;
		best_trim_d = best_trim_q;
		best_dev_d  = best_dev_q;
		res.status     = ST_IGNORED;
		res.trim_value = best_trim_q;
		res.deviation  = best_dev_q;
		if (item.action == ACT_START) begin
			searching_d = 1'b1;
			upper_d     = 1'b0;
			step_d      = FIRST_STEP;
			trial_d     = first_lower;
			best_trim_d = 8'd0;
			best_dev_d  = DEV_START;
			res.status     = ST_TRIAL;
			res.trim_value = first_lower;
			res.deviation  = DEV_START;
		end else if (searching_q) begin
			best_trim_d   = nb_trim;
			best_dev_d    = nb_dev;
			res.deviation = nb_dev;
			if (step_q[6:1] == 6'd0) begin
				step_d = FIRST_STEP;
				if (!upper_q) begin
					upper_d        = 1'b1;
					trial_d        = first_upper;
					res.status     = ST_TRIAL;
					res.trim_value = first_upper;
				end else begin
					searching_d    = 1'b0;
					upper_d        = 1'b0;
					res.status     = ST_DONE;
					res.trim_value = nb_trim;
				end
			end else begin
				step_d  = half_step;
				trial_d = len_below ? (trial_q + {1'b0, half_step})
				                    : (trial_q - {1'b0, half_step});
				res.status     = ST_TRIAL;
				res.trim_value = trial_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q <= 1'b0;
			upper_q     <= 1'b0;
			step_q      <= FIRST_STEP;
			trial_q     <= 8'd0;
			best_trim_q <= 8'd0;
			best_dev_q  <= DEV_START;
		end else if (advance) begin
			searching_q <= searching_d;
			upper_q     <= upper_d;
			step_q      <= step_d;
			trial_q     <= trial_d;
			best_trim_q <= best_trim_d;
			best_dev_q  <= best_dev_d;
		end
	end

	`ASSERT_ALWAYS(a_step_onehot, $onehot(step_q), "step size not a power of two")
	`ASSERT_IMPLIES(a_idle_lower, !searching_q, !upper_q, "upper region flagged while idle")
	`ASSERT_ALWAYS(a_best_bounded, best_dev_q <= DEV_START, "best deviation above start value")

endmodule

// File: rtl/core/ocs_out_buf.sv
// two-entry result buffer between the search logic and the output channel
`include "assert_macros.svh"

module ocs_out_buf import ocs_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  result_t        push_data,
	output logic           space,
	ocs_result_if.source   result
);

	result_t     mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign space = cnt_q != 2'd2;
	assign pop   = result.valid && result.ready;

	assign result.valid      = cnt_q != 2'd0;
	assign result.status     = mem_q[rd_ptr_q].status;
	assign result.trim_value = mem_q[rd_ptr_q].trim_value;
	assign result.deviation  = mem_q[rd_ptr_q].deviation;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_cnt_bound, cnt_q != 2'd3, "result buffer overfilled")
	`ASSERT_IMPLIES(a_ptr_match, cnt_q == 2'd0 || cnt_q == 2'd2, wr_ptr_q == rd_ptr_q,
		"buffer pointers disagree with fill level")

endmodule

// File: rtl/core/oscillator_calibration_search.sv
// top level of the oscillator trim calibration search
// Binary search of an 8-bit oscillator trim over two regions, seven trials each. A start
// transaction (action 0) resets the search and returns the first trial trim; each
// measurement transaction (action 1) returns the next trial trim, or after the fourteenth
// measurement the best trim with status done; a measurement while idle returns status
// ignored. Every transaction gives exactly one result. A transaction is taken into an input
// register, evaluated combinationally (one subtract, compare and step update) and written into a
// two-entry result buffer, so one transaction is accepted per cycle while the buffer has space.
// Its result is registered in the result buffer and presented on the output from there. The input
// stalls only while the input register holds a transaction and the result buffer is full.
// frame_target is written through frame_target_we/frame_target_wdata and must only change
// while no transaction is in flight.
module oscillator_calibration_search import ocs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         frame_target_we,
	input  logic [15:0]  frame_target_wdata,
	ocs_item_if.sink     item,
	ocs_result_if.source result
);

	logic [15:0] frame_target_q;
	item_t       item_s1;
	logic        valid_s1;
	logic        space;
	logic        advance;
	logic        accept;
	result_t     res;

	assign advance    = valid_s1 && space;
	assign item.ready = !valid_s1 || space;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_target_q <= TARGET_RESET;
		end else if (frame_target_we) begin
			frame_target_q <= frame_target_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.action       <= item.action;
			item_s1.frame_length <= item.frame_length;
		end
	end

	ocs_search u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_target (frame_target_q),
		.advance      (advance),
		.item         (item_s1),
		.res          (res)
	);

	ocs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (res),
		.space     (space),
		.result    (result)
	);

endmodule
